### hw/rtl/hdpd_pkg.sv
// ----------------------------------------------------------------------------
// hdpd_pkg
// Shared types and constants of the hot and dead pixel detector.
// ----------------------------------------------------------------------------
package hdpd_pkg;

   localparam int SAMPLE_PORT_W = 16;
   localparam int POS_W         = 13;
   localparam int COUNT_W       = 26;
   localparam int CSR_INDEX_W   = 3;
   localparam int CSR_DATA_W    = 14;
   localparam int THR_W         = 10;
   localparam int MIN_DIM       = 5;
   localparam int RST_DIM       = 8192;
   localparam int THR_BIAS      = 5;
   localparam int RATIO_NUM     = 120;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
   localparam logic [THR_W-1:0]   RST_THR   = THR_W'(100);

   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_THRESHOLD    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIND_HOT     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIND_DEAD    = 3'd4;

   // per-transaction tag carried down the pipeline
   typedef struct packed {
      logic             res_int;
      logic             out_int;
      logic             done;
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] col;
   } tag_type;

   typedef struct packed {
      logic [THR_W-1:0] threshold;
      logic             find_hot;
      logic             find_dead;
   } cfg_type;

endpackage

### hw/rtl/hot_dead_pixel_detector_core.sv
// ----------------------------------------------------------------------------
// hot_dead_pixel_detector_core
// Median residual hot and dead pixel detector for a raw mosaic stream.
// Results are registered through stages s1 to s8 and the response register,
//   the result of a pixel following its own sample by 4*W+4 transactions.
// Throughput: one transaction per cycle unless a held response stalls it,
//   each line store taking one read and one write per cycle.
// Reset clears counters and pipeline valid bits, sets default configuration;
//   the line stores are not initialized and need no clearing pass.
// ----------------------------------------------------------------------------
module hot_dead_pixel_detector_core import hdpd_pkg::*; #(
   parameter int MAX_WIDTH   = 8192,
   parameter int MAX_HEIGHT  = 8192,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [SAMPLE_PORT_W-1:0] req_sample,
   input  logic                     req_flush,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [POS_W-1:0]         rsp_pixel_row,
   output logic [POS_W-1:0]         rsp_pixel_col,
   output logic                     rsp_is_bad,
   output logic                     rsp_is_hot,
   output logic [COUNT_W-1:0]       rsp_bad_count,
   output logic                     rsp_frame_done,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_INDEX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_data
);

   localparam int AW    = $clog2(MAX_WIDTH);
   localparam int CW    = $clog2(MAX_WIDTH + 1);
   localparam int HW    = $clog2(MAX_HEIGHT + 1);
   localparam int RW    = $clog2(MAX_HEIGHT + 3);
   localparam int RST_W = (RST_DIM > MAX_WIDTH) ? MAX_WIDTH : RST_DIM;
   localparam int RST_H = (RST_DIM > MAX_HEIGHT) ? MAX_HEIGHT : RST_DIM;

   function automatic logic [CW-1:0] clamp_w(logic [CSR_DATA_W-1:0] v);
      if (int'(v) < MIN_DIM) return CW'(MIN_DIM);
      if (int'(v) > MAX_WIDTH) return CW'(MAX_WIDTH);
      return CW'(v);
   endfunction

   function automatic logic [HW-1:0] clamp_h(logic [CSR_DATA_W-1:0] v);
      if (int'(v) < MIN_DIM) return HW'(MIN_DIM);
      if (int'(v) > MAX_HEIGHT) return HW'(MAX_HEIGHT);
      return HW'(v);
   endfunction

   logic [CW-1:0]      width_ff;
   logic [HW-1:0]      height_ff;
   cfg_type            cfg_ff;
   logic [CW-1:0]      col_ff;
   logic [RW-1:0]      row_ff;
   logic [COUNT_W-1:0] cnt_ff;
   logic [COUNT_W-1:0] cnt_in;

   logic               en, restart;
   logic               in_frame, item_v, c_ge4, r_ok, out_int, res_int, last;
   logic [RW-1:0]      pr, height_x;
   logic [CW-1:0]      pc;
   tag_type            tag_in;

   logic               m_v;
   logic [AW-1:0]      m_col;
   tag_type            m_tag;
   logic               m_neg;
   logic [SAMPLE_BITS-1:0] m_mag;

   logic               j_v, j_bad, j_hot;
   tag_type            j_tag;

   logic               rsp_valid_ff;
   logic [POS_W-1:0]   rsp_row_ff, rsp_col_ff;
   logic               rsp_bad_ff, rsp_hot_ff, rsp_done_ff;
   logic [COUNT_W-1:0] rsp_count_ff;

   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;
   assign csr_ready = 1'b1;
   assign restart   = csr_valid &&
                      (csr_index == CSR_IMAGE_WIDTH || csr_index == CSR_IMAGE_HEIGHT);

   // position of the incoming transaction and of the pixels it completes
   always_comb begin
      height_x = RW'(height_ff);
      in_frame = row_ff < height_x;
      item_v   = req_valid && en && !(in_frame && req_flush);
      c_ge4    = col_ff >= CW'(4);
      pr       = c_ge4 ? row_ff - RW'(4) : row_ff - RW'(5);
      pc       = c_ge4 ? col_ff - CW'(4) : col_ff + width_ff - CW'(4);
      r_ok     = c_ge4 ? (row_ff >= RW'(6)) : (row_ff >= RW'(7));
      out_int  = r_ok && (pr <= height_x - RW'(3)) && (pc >= CW'(2))
                 && (pc <= width_ff - CW'(3));
      res_int  = c_ge4 && (row_ff >= RW'(4)) && in_frame;
      last     = (row_ff == height_x + RW'(2)) && (col_ff == CW'(1));
      tag_in.res_int = res_int;
      tag_in.out_int = out_int;
      tag_in.done    = last;
      tag_in.row     = POS_W'(pr);
      tag_in.col     = POS_W'(pc);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= CW'(RST_W);
         height_ff <= HW'(RST_H);
         cfg_ff    <= '{threshold: RST_THR, find_hot: 1'b1, find_dead: 1'b1};
         col_ff    <= '0;
         row_ff    <= '0;
         cnt_ff    <= '0;
      end else begin
         if (restart) begin
            col_ff <= '0;
            row_ff <= '0;
            cnt_ff <= '0;
         end else begin
            if (item_v) begin
               if (last) begin
                  col_ff <= '0;
                  row_ff <= '0;
               end else if (col_ff + CW'(1) == width_ff) begin
                  col_ff <= '0;
                  row_ff <= row_ff + RW'(1);
               end else begin
                  col_ff <= col_ff + CW'(1);
               end
            end
            if (en && j_v && j_tag.out_int) cnt_ff <= j_tag.done ? '0 : cnt_in;
         end
         if (csr_valid) begin
            unique case (csr_index)
               CSR_IMAGE_WIDTH:  width_ff  <= clamp_w(csr_data);
               CSR_IMAGE_HEIGHT: height_ff <= clamp_h(csr_data);
               CSR_THRESHOLD: cfg_ff.threshold <= csr_data[THR_W-1:0];
               CSR_FIND_HOT:  cfg_ff.find_hot  <= csr_data[0];
               CSR_FIND_DEAD: cfg_ff.find_dead <= csr_data[0];
               default: ;
            endcase
         end
      end
   end

   hdpd_median #(
      .SB    (SAMPLE_BITS),
      .DEPTH (MAX_WIDTH)
   ) u_median (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (item_v),
      .in_col    (col_ff[AW-1:0]),
      .in_sample (req_sample[SAMPLE_BITS-1:0]),
      .in_tag    (tag_in),
      .out_valid (m_v),
      .out_col   (m_col),
      .out_tag   (m_tag),
      .out_neg   (m_neg),
      .out_mag   (m_mag)
   );

   hdpd_judge #(
      .SB    (SAMPLE_BITS),
      .DEPTH (MAX_WIDTH)
   ) u_judge (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .cfg       (cfg_ff),
      .in_valid  (m_v),
      .in_col    (m_col),
      .in_tag    (m_tag),
      .in_neg    (m_neg),
      .in_mag    (m_mag),
      .out_valid (j_v),
      .out_tag   (j_tag),
      .out_bad   (j_bad),
      .out_hot   (j_hot)
   );

   assign cnt_in = (j_bad && cnt_ff != COUNT_MAX) ? cnt_ff + COUNT_W'(1) : cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= j_v && j_tag.out_int;
      end
   end

   always_ff @(posedge clock) begin
      if (en && j_v && j_tag.out_int) begin
         rsp_row_ff   <= j_tag.row;
         rsp_col_ff   <= j_tag.col;
         rsp_bad_ff   <= j_bad;
         rsp_hot_ff   <= j_hot;
         rsp_done_ff  <= j_tag.done;
         rsp_count_ff <= cnt_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pixel_row  = rsp_row_ff;
   assign rsp_pixel_col  = rsp_col_ff;
   assign rsp_is_bad     = rsp_bad_ff;
   assign rsp_is_hot     = rsp_hot_ff;
   assign rsp_bad_count  = rsp_count_ff;
   assign rsp_frame_done = rsp_done_ff;

`ifndef SYNTHESIS
   a_col_in_row: assert property (@(posedge clock) disable iff (reset)
      col_ff < width_ff)
      else $error("column counter beyond image width");

   a_bad_counted: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_bad_ff) |-> (rsp_count_ff != '0))
      else $error("bad pixel reported with zero count");

   a_frame_restart: assert property (@(posedge clock) disable iff (reset)
      (item_v && last) |=> (row_ff == '0 && col_ff == '0))
      else $error("position not cleared after last transaction of frame");

   a_done_column: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_done_ff) |-> (rsp_col_ff == POS_W'(width_ff - CW'(3))))
      else $error("frame done on wrong column");
`endif

endmodule

### hw/rtl/hdpd_median.sv
// ----------------------------------------------------------------------------
// hdpd_median
// Raw line store, 5x5 column window and same-color median residual.
// ----------------------------------------------------------------------------
module hdpd_median import hdpd_pkg::*; #(
   parameter int SB    = 16,
   parameter int DEPTH = 8192,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_valid,
   input  logic [AW-1:0] in_col,
   input  logic [SB-1:0] in_sample,
   input  tag_type       in_tag,
   output logic          out_valid,
   output logic [AW-1:0] out_col,
   output tag_type       out_tag,
   output logic          out_neg,
   output logic [SB-1:0] out_mag
);

   typedef logic [SB-1:0] smp_type;

   typedef struct packed {
      smp_type lo;
      smp_type mid;
      smp_type hi;
      smp_type ctr;
   } colv_type;

   function automatic smp_type max2(smp_type a, smp_type b);
      return (a > b) ? a : b;
   endfunction

   function automatic smp_type min2(smp_type a, smp_type b);
      return (a < b) ? a : b;
   endfunction

   function automatic smp_type med3(smp_type a, smp_type b, smp_type c);
      return max2(min2(a, b), min2(max2(a, b), c));
   endfunction

   logic [4*SB-1:0] mem [DEPTH];
   logic [4*SB-1:0] rd_ff;

   logic            s1_v_ff;
   logic [AW-1:0]   s1_col_ff;
   tag_type         s1_tag_ff;
   smp_type         s1_smp_ff;

   colv_type        win_ff [5];
   colv_type        colv_in;
   logic            s2_v_ff;
   logic [AW-1:0]   s2_col_ff;
   tag_type         s2_tag_ff;

   logic            s3_v_ff;
   logic [AW-1:0]   s3_col_ff;
   tag_type         s3_tag_ff;
   smp_type         s3_lo_ff, s3_md_ff, s3_hi_ff, s3_ctr_ff;
   smp_type         lo3, md3, hi3, med;

   logic            s4_v_ff;
   logic [AW-1:0]   s4_col_ff;
   tag_type         s4_tag_ff;
   logic            s4_neg_ff;
   smp_type         s4_mag_ff;
   logic            neg_in;
   smp_type         mag_in;

   // line store: slice 0 is one row up, slice 3 four rows up
   always_ff @(posedge clock) begin
      if (en && in_valid) rd_ff <= mem[in_col];
      if (en && s1_v_ff) mem[s1_col_ff] <= {rd_ff[3*SB-1:0], s1_smp_ff};
   end

   always_comb begin
      smp_type a0, a2, a4;
      a0 = s1_smp_ff;
      a2 = rd_ff[2*SB-1:SB];
      a4 = rd_ff[4*SB-1:3*SB];
      colv_in.lo  = min2(min2(a0, a2), a4);
      colv_in.hi  = max2(max2(a0, a2), a4);
      colv_in.mid = med3(a0, a2, a4);
      colv_in.ctr = a2;
   end

   always_comb begin
      lo3 = max2(max2(win_ff[0].lo, win_ff[2].lo), win_ff[4].lo);
      md3 = med3(win_ff[0].mid, win_ff[2].mid, win_ff[4].mid);
      hi3 = min2(min2(win_ff[0].hi, win_ff[2].hi), win_ff[4].hi);
   end

   always_comb begin
      med    = med3(s3_lo_ff, s3_md_ff, s3_hi_ff);
      neg_in = s3_ctr_ff < med;
      mag_in = neg_in ? (med - s3_ctr_ff) : (s3_ctr_ff - med);
      if (!s3_tag_ff.res_int) begin
         neg_in = 1'b0;
         mag_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
      end else if (en) begin
         s1_v_ff <= in_valid;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
         s4_v_ff <= s3_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_col_ff <= in_col;
         s1_tag_ff <= in_tag;
         s1_smp_ff <= in_sample;
         s2_col_ff <= s1_col_ff;
         s2_tag_ff <= s1_tag_ff;
         s3_col_ff <= s2_col_ff;
         s3_tag_ff <= s2_tag_ff;
         s3_lo_ff  <= lo3;
         s3_md_ff  <= md3;
         s3_hi_ff  <= hi3;
         s3_ctr_ff <= win_ff[2].ctr;
         s4_col_ff <= s3_col_ff;
         s4_tag_ff <= s3_tag_ff;
         s4_neg_ff <= neg_in;
         s4_mag_ff <= mag_in;
         if (s1_v_ff) begin
            win_ff[0] <= colv_in;
            for (int k = 1; k < 5; k++) win_ff[k] <= win_ff[k-1];
         end
      end
   end

   assign out_valid = s4_v_ff;
   assign out_col   = s4_col_ff;
   assign out_tag   = s4_tag_ff;
   assign out_neg   = s4_neg_ff;
   assign out_mag   = s4_mag_ff;

endmodule

### hw/rtl/hdpd_judge.sv
// ----------------------------------------------------------------------------
// hdpd_judge
// Residual line store, 5x5 neighbor sum and threshold decision.
// ----------------------------------------------------------------------------
module hdpd_judge import hdpd_pkg::*; #(
   parameter int SB    = 16,
   parameter int DEPTH = 8192,
   localparam int AW   = $clog2(DEPTH),
   localparam int RB   = SB + 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  cfg_type       cfg,
   input  logic          in_valid,
   input  logic [AW-1:0] in_col,
   input  tag_type       in_tag,
   input  logic          in_neg,
   input  logic [SB-1:0] in_mag,
   output logic          out_valid,
   output tag_type       out_tag,
   output logic          out_bad,
   output logic          out_hot
);

   typedef struct packed {
      logic          neg;
      logic [SB-1:0] mag;
   } res_type;

   typedef struct packed {
      logic [SB+2:0] sum;
      res_type       ctr;
   } rcol_type;

   logic [4*RB-1:0] mem [DEPTH];
   logic [4*RB-1:0] rd_ff;

   logic            s5_v_ff;
   logic [AW-1:0]   s5_col_ff;
   tag_type         s5_tag_ff;
   res_type         s5_res_ff;
   res_type         sl [4];
   rcol_type        rcol_in;
   rcol_type        rw_ff [5];

   logic            s6_v_ff;
   tag_type         s6_tag_ff;
   logic [SB+4:0]   total;

   logic            s7_v_ff;
   tag_type         s7_tag_ff;
   logic [SB+4:0]   s7_total_ff;
   res_type         s7_ctr_ff;
   logic [SB+4:0]   others;
   logic [SB+6:0]   lhs_in;
   logic [SB+15:0]  rhs_in;

   logic            s8_v_ff;
   tag_type         s8_tag_ff;
   logic [SB+6:0]   s8_lhs_ff;
   logic [SB+15:0]  s8_rhs_ff;
   logic            s8_neg_ff;
   logic            s8_zero_ff;
   logic            skip;

   always_ff @(posedge clock) begin
      if (en && in_valid) rd_ff <= mem[in_col];
      if (en && s5_v_ff) mem[s5_col_ff] <= {rd_ff[3*RB-1:0], s5_res_ff};
   end

   always_comb begin
      for (int k = 0; k < 4; k++) sl[k] = rd_ff[k*RB +: RB];
      rcol_in.sum = (SB+3)'(s5_res_ff.mag) + (SB+3)'(sl[0].mag) + (SB+3)'(sl[1].mag)
                  + (SB+3)'(sl[2].mag) + (SB+3)'(sl[3].mag);
      rcol_in.ctr = sl[1];
   end

   always_comb begin
      total = (SB+5)'(rw_ff[0].sum) + (SB+5)'(rw_ff[1].sum) + (SB+5)'(rw_ff[2].sum)
            + (SB+5)'(rw_ff[3].sum) + (SB+5)'(rw_ff[4].sum);
   end

   always_comb begin
      others = s7_total_ff - (SB+5)'(s7_ctr_ff.mag);
      lhs_in = (SB+7)'(s7_ctr_ff.mag) * (SB+7)'(RATIO_NUM);
      rhs_in = (SB+16)'((THR_W+1)'(cfg.threshold) + (THR_W+1)'(THR_BIAS)) * (SB+16)'(others);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_v_ff <= 1'b0;
         s6_v_ff <= 1'b0;
         s7_v_ff <= 1'b0;
         s8_v_ff <= 1'b0;
      end else if (en) begin
         s5_v_ff <= in_valid;
         s6_v_ff <= s5_v_ff;
         s7_v_ff <= s6_v_ff;
         s8_v_ff <= s7_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s5_col_ff   <= in_col;
         s5_tag_ff   <= in_tag;
         s5_res_ff   <= '{neg: in_neg, mag: in_mag};
         s6_tag_ff   <= s5_tag_ff;
         s7_tag_ff   <= s6_tag_ff;
         s7_total_ff <= total;
         s7_ctr_ff   <= rw_ff[2].ctr;
         s8_tag_ff   <= s7_tag_ff;
         s8_lhs_ff   <= lhs_in;
         s8_rhs_ff   <= rhs_in;
         s8_neg_ff   <= s7_ctr_ff.neg;
         s8_zero_ff  <= (s7_ctr_ff.mag == '0);
         if (s5_v_ff) begin
            rw_ff[0] <= rcol_in;
            for (int k = 1; k < 5; k++) rw_ff[k] <= rw_ff[k-1];
         end
      end
   end

   // polarity masking, zero residual counts as both
   assign skip = (!cfg.find_dead && (s8_neg_ff || s8_zero_ff)) ||
                 (!cfg.find_hot && !s8_neg_ff);

   assign out_valid = s8_v_ff;
   assign out_tag   = s8_tag_ff;
   assign out_bad   = !skip && ((SB+16)'(s8_lhs_ff) > s8_rhs_ff);
   assign out_hot   = !s8_neg_ff && !s8_zero_ff;

endmodule
